[src/fat12_pkg.sv]
// Shared types, constants and codes of the FAT12 cluster chain walker.
`default_nettype none

package fat12_pkg;

  localparam int TABLE_BYTES = 8192;
  localparam int TABLE_AW    = $clog2(TABLE_BYTES);
  localparam int CLUS_W      = 12;
  localparam int IDX_W       = CLUS_W + 2;
  localparam int CFG_W       = 16;
  localparam int SECT_W      = 32;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_WRITE = 2'd0;
  localparam opcode_t OP_START = 2'd1;
  localparam opcode_t OP_ADV   = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK  = 2'd0;
  localparam status_t ST_END = 2'd1;
  localparam status_t ST_BAD = 2'd2;

  typedef logic [2:0] cfg_index_t;
  localparam cfg_index_t REG_RESERVED  = 3'd0;
  localparam cfg_index_t REG_COPIES    = 3'd1;
  localparam cfg_index_t REG_SPT       = 3'd2;
  localparam cfg_index_t REG_ROOT      = 3'd3;
  localparam cfg_index_t REG_SPC       = 3'd4;

  localparam logic [CLUS_W-1:0] CLUS_END_MARK = 12'hFF8;
  localparam logic [CLUS_W-1:0] CLUS_FIRST    = 12'd2;

  typedef struct packed {
    logic        en;
    logic        clear;
    logic [15:0] a;
    logic [15:0] b;
  } mac_ctrl_t;

endpackage

`default_nettype wire

[src/fat12_table_ram.sv]
// Single-port byte store holding the allocation table, registered read.
`default_nettype none

module fat12_table_ram
  import fat12_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [TABLE_AW-1:0] addr,
  input  wire logic [7:0]          wdata,
  output logic      [7:0]          rdata
);

  logic [7:0] mem [TABLE_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[src/fat12_mac_unit.sv]
// Shared multiply-accumulate unit used to build sector addresses term by term.
`default_nettype none

module fat12_mac_unit
  import fat12_pkg::*;
(
  input  wire logic              clk,
  input  wire mac_ctrl_t         ctrl,
  output logic      [SECT_W-1:0] acc
);

  logic [SECT_W-1:0] prod;
  logic [SECT_W-1:0] acc_next;

  assign prod     = ctrl.a * ctrl.b;
  assign acc_next = (ctrl.clear ? '0 : acc) + prod;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc <= acc_next;
    end
  end

endmodule

`default_nettype wire

[src/fat12_cluster_chain_walker.sv]
// Top level: FAT12 table store, chain sequencer and sector address builder.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command beat: opcode 0
//   writes table_byte at table_addr, opcode 1 starts a chain at
//   start_cluster, opcode 2 follows the current chain one link. Opcode 3 is
//   dropped. Opcodes 0 and 3 produce no result; 1 and 2 produce one beat on
//   the output channel (out_valid/out_ready): sector_addr, cluster, status
//   (0 valid, 1 end of chain, 2 bad cluster) and last.
//   A table write or unused opcode leaves the sequencer idle; in_ready stays
//   high. A bad start or an advance with no live chain goes straight to the
//   done state; a good start makes four passes through the multiply-accumulate
//   unit; an advance makes two reads through the single table port, then four
//   passes through the shared unit if the link is live. in_ready is low from
//   acceptance until the result is loaded into the output register.
//   If the receiver stalls, the sequencer holds its finished result until
//   the output register frees; the output beat holds steady meanwhile.
//   Reset clears the sequencer, the chain state and the output valid, and
//   loads the volume geometry defaults; the table store is not cleared and
//   must be written before it is walked. Configuration writes (cfg_wr_en,
//   cfg_index, cfg_data) are registered and are meant for idle periods.
`default_nettype none

module fat12_cluster_chain_walker
  import fat12_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // command channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        opcode,
  input  wire logic [12:0]       table_addr,
  input  wire logic [7:0]        table_byte,
  input  wire logic [11:0]       start_cluster,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [31:0]       sector_addr,
  output logic      [11:0]       cluster,
  output logic      [1:0]        status,
  output logic                   last,
  // configuration write port
  input  wire logic              cfg_wr_en,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD0  = 6'b000010,
    S_RD1  = 6'b000100,
    S_MAC  = 6'b001000,
    S_DONE = 6'b010000,
    S_HOLD = 6'b100000
  } state_t;

  localparam logic [1:0] STEP_RESERVED = 2'd0;
  localparam logic [1:0] STEP_TABLES   = 2'd1;
  localparam logic [1:0] STEP_ROOT     = 2'd2;
  localparam logic [1:0] STEP_CLUSTER  = 2'd3;

  // Volume geometry registers.
  logic [15:0] reserved_sectors;
  logic [7:0]  table_copies;
  logic [15:0] sectors_per_table;
  logic [15:0] root_dir_sectors;
  logic [7:0]  sectors_per_cluster;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_sectors    <= 16'd1;
      table_copies        <= 8'd2;
      sectors_per_table   <= 16'd9;
      root_dir_sectors    <= 16'd14;
      sectors_per_cluster <= 8'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RESERVED: reserved_sectors    <= cfg_data;
        REG_COPIES:   table_copies        <= cfg_data[7:0];
        REG_SPT:      sectors_per_table   <= cfg_data;
        REG_ROOT:     root_dir_sectors    <= cfg_data;
        REG_SPC:      sectors_per_cluster <= cfg_data[7:0];
        default:      ;
      endcase
    end
  end

  // Sequencer and chain state.
  state_t            state, state_next;
  logic [CLUS_W-1:0] current_cluster;
  logic              chain_active;
  logic [1:0]        step;
  logic [7:0]        b0;
  logic              rd_ok;
  status_t           res_status;
  logic [CLUS_W-1:0] res_cluster;

  logic              accept;
  logic              out_free;
  logic [IDX_W-1:0]  entry_idx;
  logic [IDX_W-1:0]  rd_idx;
  logic [7:0]        rdata;
  logic [7:0]        rbyte;
  logic [CLUS_W-1:0] entry;
  logic              start_bad;
  logic              ram_we;
  logic [TABLE_AW-1:0] ram_addr;
  mac_ctrl_t         mac_ctrl;
  logic [SECT_W-1:0] acc;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Entry of cluster c sits at byte c + c/2.
  assign entry_idx = IDX_W'(current_cluster) + IDX_W'(current_cluster[CLUS_W-1:1]);
  assign rd_idx    = (state == S_RD0) ? entry_idx + IDX_W'(1) : entry_idx;

  assign ram_we   = accept && (opcode == OP_WRITE) &&
                    (IDX_W'(table_addr) < IDX_W'(TABLE_BYTES));
  assign ram_addr = ram_we ? table_addr[TABLE_AW-1:0] : rd_idx[TABLE_AW-1:0];

  fat12_table_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (table_byte),
    .rdata (rdata)
  );

  // Bytes past the end of the store read as zero.
  always_ff @(posedge clk) begin
    rd_ok <= (rd_idx < IDX_W'(TABLE_BYTES));
  end

  assign rbyte = rd_ok ? rdata : 8'd0;

  // Even cluster: low byte plus low nibble of next; odd: high nibble plus next.
  assign entry = current_cluster[0] ? {rbyte, b0[7:4]} : {rbyte[3:0], b0};

  assign start_bad = (start_cluster < CLUS_FIRST) || (start_cluster >= CLUS_END_MARK);

  // Operand select for the shared multiply-accumulate unit.
  always_comb begin
    mac_ctrl.en    = (state == S_MAC);
    mac_ctrl.clear = (step == STEP_RESERVED);
    case (step)
      STEP_RESERVED: begin
        mac_ctrl.a = reserved_sectors;
        mac_ctrl.b = 16'd1;
      end
      STEP_TABLES: begin
        mac_ctrl.a = {8'd0, table_copies};
        mac_ctrl.b = sectors_per_table;
      end
      STEP_ROOT: begin
        mac_ctrl.a = root_dir_sectors;
        mac_ctrl.b = 16'd1;
      end
      default: begin
        mac_ctrl.a = 16'(current_cluster - CLUS_FIRST);
        mac_ctrl.b = {8'd0, sectors_per_cluster};
      end
    endcase
  end

  fat12_mac_unit u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .acc  (acc)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (opcode == OP_START) begin
            state_next = start_bad ? S_DONE : S_MAC;
          end else if (opcode == OP_ADV) begin
            state_next = chain_active ? S_RD0 : S_DONE;
          end
        end
      end
      S_RD0:  state_next = S_RD1;
      S_RD1: begin
        state_next = ((entry >= CLUS_END_MARK) || (entry < CLUS_FIRST)) ? S_DONE : S_MAC;
      end
      S_MAC:  state_next = (step == STEP_CLUSTER) ? S_DONE : S_MAC;
      S_DONE: state_next = out_free ? S_IDLE : S_HOLD;
      S_HOLD: state_next = out_free ? S_IDLE : S_HOLD;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      current_cluster <= '0;
      chain_active    <= 1'b0;
      step            <= STEP_RESERVED;
    end else begin
      state <= state_next;
      step  <= (state == S_MAC) ? step + 2'd1 : STEP_RESERVED;
      if (accept && (opcode == OP_START)) begin
        chain_active <= !start_bad;
        if (!start_bad) begin
          current_cluster <= start_cluster;
        end
      end
      if (state == S_RD1) begin
        if ((entry >= CLUS_END_MARK) || (entry < CLUS_FIRST)) begin
          chain_active <= 1'b0;
        end else begin
          current_cluster <= entry;
        end
      end
    end
  end

  // Pending result fields and captured first byte.
  always_ff @(posedge clk) begin
    if (state == S_RD0) begin
      b0 <= rbyte;
    end
    if (accept && (opcode == OP_START)) begin
      res_cluster <= start_cluster;
      res_status  <= start_bad ? ST_BAD : ST_OK;
    end
    if (accept && (opcode == OP_ADV) && !chain_active) begin
      res_cluster <= '0;
      res_status  <= ST_END;
    end
    if (state == S_RD1) begin
      res_cluster <= entry;
      if (entry >= CLUS_END_MARK) begin
        res_status <= ST_END;
      end else if (entry < CLUS_FIRST) begin
        res_status <= ST_BAD;
      end else begin
        res_status <= ST_OK;
      end
    end
  end

  // Output register: load when the result is ready and the slot is free.
  logic load_out;
  assign load_out = ((state == S_DONE) || (state == S_HOLD)) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sector_addr <= (res_status == ST_OK) ? acc : '0;
      cluster     <= res_cluster;
      status      <= res_status;
      last        <= (res_status != ST_OK);
    end
  end

endmodule

`default_nettype wire

[src/fat12_checker.sv]
// Port-level checker for the chain walker, bound to the top level.
`default_nettype none

module fat12_checker
  import fat12_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  opcode,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] sector_addr,
  input wire logic [11:0] cluster,
  input wire logic [1:0]  status,
  input wire logic        last
);

  a_last_matches_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (status != ST_OK)))
    else $error("last disagrees with status");

  a_no_sector_on_fail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> (sector_addr == 32'd0))
    else $error("sector address nonzero on failed beat");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && ((opcode == OP_START) || (opcode == OP_ADV))) |=> !in_ready)
    else $error("ready while a chain command is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(cluster) && $stable(status)))
    else $error("stalled result beat changed");

endmodule

bind fat12_cluster_chain_walker fat12_checker u_fat12_checker (.*);

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the FAT12 cluster chain walker.
`timescale 1ns / 1ps

module testbench;
  import fat12_pkg::*;

  // Opcode 3 has no name in the package; the block drops it.
  localparam opcode_t     OP_UNUSED    = 2'd3;
  localparam int          DRAIN_CYCLES = 16;      // covers a full advance
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          IDLE_PCT     = 35;

  // One result beat as the block should present it.
  typedef struct packed {
    logic [31:0] sector;
    logic [11:0] clus;
    status_t     st;
    logic        last;
  } hop_t;

  logic              clk;
  logic              rst           = 1'b1;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic [1:0]        opcode        = '0;
  logic [12:0]       table_addr    = '0;
  logic [7:0]        table_byte    = '0;
  logic [11:0]       start_cluster = '0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic [31:0]       sector_addr;
  logic [11:0]       cluster;
  logic [1:0]        status;
  logic              last;
  logic              cfg_wr_en     = 1'b0;
  logic [2:0]        cfg_index     = '0;
  logic [CFG_W-1:0]  cfg_data      = '0;

  // Mirror of the block: table image, which bytes have been written, chain
  // position and volume geometry. Geometry is held at 32 bits so the sector
  // sum wraps the same way as the hardware.
  logic [7:0]        table_img   [TABLE_BYTES];
  bit                table_known [TABLE_BYTES];
  logic [11:0]       cur_clus    = '0;
  bit                chain_live  = 1'b0;
  logic [31:0]       reserved_r  = 32'd1;
  logic [31:0]       copies_r    = 32'd2;
  logic [31:0]       spt_r       = 32'd9;
  logic [31:0]       root_r      = 32'd14;
  logic [31:0]       spc_r       = 32'd1;

  hop_t              predicted_hops [$];
  int unsigned       beats_sent     = 0;
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count    = 0;
  bit                calm           = 1'b0;   // no idling on either side

  fat12_cluster_chain_walker u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .table_addr    (table_addr),
    .table_byte    (table_byte),
    .start_cluster (start_cluster),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sector_addr   (sector_addr),
    .cluster       (cluster),
    .status        (status),
    .last          (last),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop if the block hangs or stops handing back beats.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fat12_cluster_chain_walker verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("[%0t] mismatch: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic logic [31:0] first_sector(logic [11:0] c);
    return reserved_r + copies_r * spt_r + root_r + (32'(c) - 32'd2) * spc_r;
  endfunction

  function automatic hop_t make_hop(logic [31:0] sector, logic [11:0] c, status_t st);
    hop_t h;
    h.sector = sector;
    h.clus   = c;
    h.st     = st;
    h.last   = (st != ST_OK);
    return h;
  endfunction

  // Apply one accepted command to the mirror; return 1 when it yields a beat.
  function automatic bit predict_walk(opcode_t op, logic [12:0] addr, logic [7:0] data,
                                      logic [11:0] start, output hop_t hop);
    logic [13:0] idx;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [11:0] link;
    bit          has_hop;
    hop     = '0;
    has_hop = 1'b1;
    case (op)
      OP_WRITE: begin
        table_img[addr]   = data;
        table_known[addr] = 1'b1;
        has_hop           = 1'b0;
      end
      OP_START: begin
        if (start < CLUS_FIRST || start >= CLUS_END_MARK) begin
          chain_live = 1'b0;
          hop        = make_hop('0, start, ST_BAD);
        end else begin
          cur_clus   = start;
          chain_live = 1'b1;
          hop        = make_hop(first_sector(start), start, ST_OK);
        end
      end
      OP_ADV: begin
        if (!chain_live) begin
          hop = make_hop('0, '0, ST_END);
        end else begin
          // Entry sits at byte cluster + cluster/2; odd clusters own the
          // high nibble of the first byte, even ones the low nibble of the next.
          idx  = 14'(cur_clus) + 14'(cur_clus >> 1);
          b0   = table_img[idx];
          b1   = table_img[idx + 1];
          link = cur_clus[0] ? {b1, b0[7:4]} : {b1[3:0], b0};
          if (link >= CLUS_END_MARK) begin
            chain_live = 1'b0;
            hop        = make_hop('0, link, ST_END);
          end else if (link < CLUS_FIRST) begin
            chain_live = 1'b0;
            hop        = make_hop('0, link, ST_BAD);
          end else begin
            cur_clus = link;
            hop      = make_hop(first_sector(link), link, ST_OK);
          end
        end
      end
      default: has_hop = 1'b0;
    endcase
    return has_hop;
  endfunction

  // ---------------------------------------------------------------------
  // Result checking: every accepted output beat against the oldest hop.
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    hop_t want;
    out_ready <= !rst && (calm || $urandom_range(99) >= IDLE_PCT);
    if (!rst && out_valid && out_ready) begin
      if (predicted_hops.size() == 0) begin
        report_mismatch($sformatf("unexpected beat cluster=%03h status=%0d", cluster, status));
      end else begin
        want = predicted_hops.pop_front();
        if (sector_addr !== want.sector)
          report_mismatch($sformatf("sector_addr %08h, want %08h", sector_addr, want.sector));
        if (cluster !== want.clus)
          report_mismatch($sformatf("cluster %03h, want %03h", cluster, want.clus));
        if (status !== want.st)
          report_mismatch($sformatf("status %0d, want %0d", status, want.st));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", last, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Present one command beat and hold it until accepted. Valid stays high on
  // return so the next beat can follow without a bubble.
  task automatic send_cmd(opcode_t op, logic [12:0] addr, logic [7:0] data,
                          logic [11:0] start);
    hop_t hop;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    table_addr    <= addr;
    table_byte    <= data;
    start_cluster <= start;
    do @(posedge clk); while (!in_ready);
    if (predict_walk(op, addr, data, start, hop))
      predicted_hops.push_back(hop);
    if (op != OP_UNUSED)
      beats_sent++;
  endtask

  // Drop valid, wait for every predicted hop, then let write-only work finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (predicted_hops.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic poke_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Write all five geometry registers back to back; only call while idle.
  task automatic apply_geometry(logic [CFG_W-1:0] rsv, logic [CFG_W-1:0] cps,
                                logic [CFG_W-1:0] spt, logic [CFG_W-1:0] root,
                                logic [CFG_W-1:0] spc);
    cfg_wr_en <= 1'b1;
    poke_reg(REG_RESERVED, rsv);
    poke_reg(REG_COPIES, cps);
    poke_reg(REG_SPT, spt);
    poke_reg(REG_ROOT, root);
    poke_reg(REG_SPC, spc);
    cfg_wr_en <= 1'b0;
    // 8-bit registers keep only their low byte
    reserved_r = 32'(rsv);
    copies_r   = 32'(cps[7:0]);
    spt_r      = 32'(spt);
    root_r     = 32'(root);
    spc_r      = 32'(spc[7:0]);
  endtask

  function automatic logic [11:0] rand_cluster();
    return 12'($urandom_range(CLUS_END_MARK - 1, CLUS_FIRST));
  endfunction

  // Pick a link value: end marker, free/reserved entry, or a live cluster.
  function automatic logic [11:0] chain_tail();
    case ($urandom_range(3))
      0:       return 12'($urandom_range(12'hFFF, CLUS_END_MARK));
      1:       return 12'($urandom_range(1, 0));
      default: return rand_cluster();
    endcase
  endfunction

  // Store a 12-bit link for cluster c as two byte writes, keeping the
  // neighbor's nibble in the shared byte.
  task automatic set_link(logic [11:0] c, logic [11:0] val);
    logic [13:0] idx;
    logic [7:0]  b0;
    logic [7:0]  b1;
    idx = 14'(c) + 14'(c >> 1);
    b0  = table_img[idx];
    b1  = table_img[idx + 1];
    if (c[0]) begin
      b0[7:4] = val[3:0];
      b1      = val[11:4];
    end else begin
      b0      = val[7:0];
      b1[3:0] = val[11:8];
    end
    send_cmd(OP_WRITE, 13'(idx), b0, 12'($urandom));
    send_cmd(OP_WRITE, 13'(idx + 1), b1, 12'($urandom));
  endtask

  // Advance the chain; never let the block read table bytes nobody wrote.
  task automatic follow_link();
    logic [13:0] idx;
    idx = 14'(cur_clus) + 14'(cur_clus >> 1);
    if (chain_live && !(table_known[idx] && table_known[idx + 1]))
      set_link(cur_clus, chain_tail());
    send_cmd(OP_ADV, 13'($urandom), 8'($urandom), 12'($urandom));
  endtask

  // Well-formed walk: start, then link-and-advance for each hop.
  task automatic chain_walk(int unsigned links);
    logic [11:0] here;
    logic [11:0] next;
    here = rand_cluster();
    send_cmd(OP_START, 13'($urandom), 8'($urandom), here);
    for (int unsigned i = 0; i < links; i++) begin
      next = (i + 1 == links) ? chain_tail() : rand_cluster();
      set_link(here, next);
      follow_link();
      here = next;
    end
    // sometimes poke past the end of the chain
    if ($urandom_range(3) == 0)
      follow_link();
  endtask

  task automatic noise_beat();
    case (opcode_t'($urandom_range(3)))
      OP_WRITE: send_cmd(OP_WRITE, 13'($urandom), 8'($urandom), 12'($urandom));
      OP_START: send_cmd(OP_START, 13'($urandom), 8'($urandom), 12'($urandom));
      OP_ADV:   follow_link();
      default:  send_cmd(OP_UNUSED, 13'($urandom), 8'($urandom), 12'($urandom));
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Field extremes, every opcode and each corner of the walk, at reset geometry.
  task automatic test_directed_cases();
    follow_link();                                        // advance with no chain
    send_cmd(OP_UNUSED, '1, '1, '1);                      // dropped, no beat
    send_cmd(OP_WRITE, '1, '1, '0);                       // top of the table
    send_cmd(OP_START, '0, '0, 12'd0);                    // bad starts
    send_cmd(OP_START, '0, '0, 12'd1);
    send_cmd(OP_START, '0, '0, CLUS_END_MARK);
    send_cmd(OP_START, '0, '0, '1);
    send_cmd(OP_START, '0, '0, CLUS_END_MARK - 12'd1);    // highest good start
    set_link(CLUS_END_MARK - 12'd1, '1);
    follow_link();                                        // end marker FFF
    follow_link();                                        // chain now idle
    // 2 -> 3 -> FF8: even then odd entry sharing byte 4
    send_cmd(OP_START, '0, '0, CLUS_FIRST);
    set_link(12'd2, 12'd3);
    set_link(12'd3, CLUS_END_MARK);
    follow_link();
    follow_link();
    // free link ends the chain as bad
    set_link(12'd4, 12'd0);
    send_cmd(OP_START, '0, '0, 12'd4);
    follow_link();
  endtask

  // Walk short chains under extreme and out-of-range geometry.
  task automatic test_geometry_settings();
    logic [CFG_W-1:0] geo [6][5];
    geo[0] = '{16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0001};  // minimum
    geo[1] = '{16'hFFFF, 16'h00FF, 16'hFFFF, 16'hFFFF, 16'h0080};  // maximum
    geo[2] = '{16'h1234, 16'h0000, 16'hFFFF, 16'h0020, 16'h0000};  // zero copies/spc
    geo[3] = '{16'hFFFF, 16'hA5FF, 16'h8001, 16'hFFFF, 16'h5AFF};  // junk upper bytes
    geo[4] = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    geo[5] = '{16'd1, 16'd2, 16'd9, 16'd14, 16'd1};                // back to defaults
    for (int g = 0; g < 6; g++) begin
      settle();
      apply_geometry(geo[g][0], geo[g][1], geo[g][2], geo[g][3], geo[g][4]);
      send_cmd(OP_START, '0, '0, CLUS_END_MARK - 12'd1);
      send_cmd(OP_START, '0, '0, CLUS_FIRST);
      chain_walk(3);
    end
  endtask

  // Mostly valid walks with random content, the rest noise; new random
  // geometry per phase, and one phase with no idling at all.
  task automatic test_random_traffic();
    int unsigned stop_at;
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      apply_geometry(16'($urandom), {8'($urandom), 8'($urandom_range(255, 1))},
                     16'($urandom), 16'($urandom),
                     {8'($urandom), 8'($urandom_range(128, 1))});
      calm    = (phase == 2);
      stop_at = beats_sent + 110;
      while (beats_sent < stop_at) begin
        if ($urandom_range(99) < 70)
          chain_walk($urandom_range(6, 1));
        else
          noise_beat();
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    // unwritten bytes only ever feed the neighbor nibble of a link write
    for (int i = 0; i < TABLE_BYTES; i++) begin
      table_img[i]   = 8'($urandom);
      table_known[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_geometry_settings();
    test_random_traffic();
    settle();

    if (mismatch_count == 0)
      $display("fat12_cluster_chain_walker verification clean");
    else
      $display("fat12_cluster_chain_walker verification failed");
    $finish;
  end

endmodule
